>>> rtl/c8_pkg.sv
// c8_pkg: shared types and constants for the chip8 instruction core
// no dependencies

package c8_pkg;

   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_FRAME = 2'd2;
   localparam logic [1:0] REQ_EXEC  = 2'd3;

   localparam logic [1:0] CSR_PROGRAM_START = 2'd0;
   localparam logic [1:0] CSR_STACK_BASE    = 2'd1;
   localparam logic [1:0] CSR_FONT_BASE     = 2'd2;

   // alu operation codes for the shared unit
   typedef enum logic [3:0] {
      ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR, ALU_SUBN,
      ALU_SHL, ALU_ADDK
   } alu_op_type;

   typedef struct packed {
      logic [7:0] result;
      logic       flag;
   } alu_out_type;

endpackage

>>> rtl/c8_alu.sv
// c8_alu: the shared 8-bit arithmetic unit used by the decode step
// depends on c8_pkg

module c8_alu (
   input  c8_pkg::alu_op_type  op,
   input  logic [7:0]          a,
   input  logic [7:0]          b,
   output c8_pkg::alu_out_type res
);

   logic [8:0] sum;
   logic [8:0] dif;
   logic [8:0] difn;

   assign sum  = {1'b0, a} + {1'b0, b};
   assign dif  = {1'b0, a} - {1'b0, b};
   assign difn = {1'b0, b} - {1'b0, a};

   always_comb begin
      res = '0;
      case (op)
         c8_pkg::ALU_MOV:  res.result = b;
         c8_pkg::ALU_OR:   res.result = a | b;
         c8_pkg::ALU_AND:  res.result = a & b;
         c8_pkg::ALU_XOR:  res.result = a ^ b;
         c8_pkg::ALU_ADD: begin
            res.result = sum[7:0];
            res.flag = sum[8];
         end
         c8_pkg::ALU_ADDK: res.result = sum[7:0];
         c8_pkg::ALU_SUB: begin
            res.result = dif[7:0];
            res.flag = ~dif[8];
         end
         c8_pkg::ALU_SUBN: begin
            res.result = difn[7:0];
            res.flag = ~difn[8];
         end
         c8_pkg::ALU_SHR: begin
            res.result = {1'b0, a[7:1]};
            res.flag = a[0];
         end
         c8_pkg::ALU_SHL: begin
            res.result = {a[6:0], 1'b0};
            res.flag = a[7];
         end
         default: res = '0;
      endcase
   end

endmodule

>>> rtl/chip8_instruction_core.sv
// chip8_instruction_core: top level with sequencer, ram, frame store and registers
// depends on c8_pkg and c8_alu

// One request is accepted at a time on start/busy; busy stays high until the response
// strobe. A RAM write goes from S_MRD to S_DONE and a RAM or frame read adds a wait
// state; an instruction is fetched (S_F0, S_F1, S_F2), decoded and done, with added
// states for a call, a return, BCD, each register in FX55/FX65, a clear, and a draw:
// per sprite row a ram fetch, then a read and a write of each of its two frame bytes,
// then a final state that sets VF. The single-port RAM and frame store set these
// steps. The longest request is a clear. After reset the frame store is cleared while
// busy is high. rsp_valid is held one cycle; the receiver cannot stall it.

module chip8_instruction_core #(
   parameter int RAM_BYTES     = 4096,
   parameter int SCREEN_WIDTH  = 64,
   parameter int SCREEN_HEIGHT = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [11:0] req_address,
   input  logic [7:0]  req_write_data,
   input  logic [7:0]  req_random_byte,
   output logic        rsp_valid,
   output logic [7:0]  rsp_read_data,
   output logic [11:0] rsp_pc_after,
   output logic        rsp_illegal_opcode,
   output logic        rsp_display_updated,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_data
);

   localparam int RAM_AW   = $clog2(RAM_BYTES);
   localparam int ROW_B    = SCREEN_WIDTH / 8;
   localparam int FR_BYTES = ROW_B * SCREEN_HEIGHT;
   localparam int FR_AW    = $clog2(FR_BYTES);
   localparam int COL_W    = $clog2(ROW_B);
   localparam int ROW_W    = $clog2(SCREEN_HEIGHT);
   localparam int PX_W     = $clog2(SCREEN_WIDTH);

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_MRD, S_MWAIT, S_FRD, S_FWAIT, S_F0, S_F1, S_F2,
      S_DEC, S_SCALL, S_RET0, S_RET1, S_RET2, S_BCD, S_BLK, S_BLKW,
      S_DROW, S_DROWW, S_DRD, S_DRW, S_DWR, S_CLR, S_DONE
   } state_type;

   logic [7:0] ram [RAM_BYTES];
   logic [7:0] frame [FR_BYTES];

   state_type   state_ff;
   logic [11:0] pstart_ff, sbase_ff, fbase_ff;
   logic [11:0] pc_ff, sp_ff;
   logic [15:0] idx_ff;
   logic [7:0]  dt_ff, st_ff;
   logic [7:0]  v_ff [16];
   logic [1:0]  rtype_ff;
   logic [11:0] raddr_ff;
   logic [7:0]  wdata_ff, rnd_ff;
   logic [7:0]  b0_ff, b1_ff;
   logic [7:0]  ram_q_ff, frame_q_ff;
   logic [FR_AW:0] cnt_ff;
   logic [4:0]  step_ff;
   logic [15:0] line_ff;
   logic        hit_ff;
   logic [7:0]  rd_ff;
   logic        ill_ff, disp_ff, valid_ff;

   // ram and frame store ports
   logic        ram_we;
   logic [11:0] ram_a;
   logic [7:0]  ram_d;
   logic        fr_we;
   logic [FR_AW-1:0] fr_a;
   logic [7:0]  fr_d;

   always_ff @(posedge clock) begin
      if (ram_we) ram[ram_a[RAM_AW-1:0]] <= ram_d;
      ram_q_ff <= ram[ram_a[RAM_AW-1:0]];
      if (fr_we) frame[fr_a] <= fr_d;
      frame_q_ff <= frame[fr_a];
   end

   logic [3:0] x, y, n;
   logic [11:0] nnn, pc2, pc4;
   logic [7:0] vx, vy;
   assign x = b0_ff[3:0];
   assign y = b1_ff[7:4];
   assign n = b1_ff[3:0];
   assign nnn = {x, b1_ff};
   assign vx = v_ff[x];
   assign vy = v_ff[y];
   assign pc2 = pc_ff + 12'd2;
   assign pc4 = pc_ff + 12'd4;

   c8_pkg::alu_op_type  aop;
   logic [7:0]          aa, ab;
   c8_pkg::alu_out_type ares;
   c8_alu u_alu (.op(aop), .a(aa), .b(ab), .res(ares));

   // draw geometry
   logic [ROW_W-1:0] drow;
   logic [PX_W-1:0]  px0;
   logic [COL_W-1:0] dcol;
   logic [2:0]       sh;
   logic [FR_AW-1:0] dbyte;
   logic [7:0]       dmask;
   logic [15:0]      lsh;
   assign drow  = ROW_W'(vy + 8'(step_ff));
   assign px0   = vx[PX_W-1:0];
   assign sh    = px0[2:0];
   assign lsh   = {line_ff[15:8], 8'h00} >> sh;
   assign dcol  = COL_W'(px0[PX_W-1:3]) + COL_W'(cnt_ff[0]);
   assign dbyte = FR_AW'({drow, dcol});
   assign dmask = cnt_ff[0] ? lsh[7:0] : lsh[15:8];

   // bcd digits by reciprocal multiplication
   logic [15:0] q10_prod, q100_prod;
   logic [7:0]  q10, q100;
   logic [7:0]  bcd_d;
   assign q10_prod  = {8'h00, vx} * 16'd205;
   assign q100_prod = {8'h00, vx} * 16'd41;
   assign q10  = {3'd0, q10_prod[15:11]};
   assign q100 = {4'd0, q100_prod[15:12]};
   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    bcd_d = q100;
         2'd1:    bcd_d = q10 - ({q100[4:0], 3'b000} + {q100[6:0], 1'b0});
         default: bcd_d = vx - ({q10[4:0], 3'b000} + {q10[6:0], 1'b0});
      endcase
   end

   logic [11:0] iaddr;
   assign iaddr = idx_ff[11:0] + 12'(cnt_ff);

   always_comb begin
      ram_we = 1'b0;
      ram_a  = raddr_ff;
      ram_d  = wdata_ff;
      fr_we  = 1'b0;
      fr_a   = raddr_ff[FR_AW-1:0];
      fr_d   = '0;
      aop    = c8_pkg::ALU_MOV;
      aa     = vx;
      ab     = vy;
      case (state_ff)
         S_CLEAR, S_CLR: begin
            fr_we = 1'b1;
            fr_a  = cnt_ff[FR_AW-1:0];
         end
         S_MRD: ram_we = (rtype_ff == c8_pkg::REQ_WRITE);
         S_F0:  ram_a = pc_ff;
         S_F1:  ram_a = pc_ff + 12'd1;
         S_SCALL: begin
            ram_we = 1'b1;
            ram_a  = sp_ff + 12'(cnt_ff[0]);
            ram_d  = cnt_ff[0] ? pc2[7:0] : {4'h0, pc2[11:8]};
         end
         S_RET0: ram_a = sp_ff;
         S_RET1: ram_a = sp_ff + 12'd1;
         S_BCD: begin
            ram_we = 1'b1;
            ram_a  = iaddr;
            ram_d  = bcd_d;
         end
         S_BLK: begin
            ram_a  = iaddr;
            ram_we = (b1_ff == 8'h55);
            ram_d  = v_ff[cnt_ff[3:0]];
         end
         S_DROW: ram_a = idx_ff[11:0] + 12'(step_ff);
         S_DRD:  fr_a = dbyte;
         S_DWR: begin
            fr_a  = dbyte;
            fr_we = 1'b1;
            fr_d  = frame_q_ff ^ dmask;
         end
         S_DEC: begin
            case (n)
               4'h1: aop = c8_pkg::ALU_OR;
               4'h2: aop = c8_pkg::ALU_AND;
               4'h3: aop = c8_pkg::ALU_XOR;
               4'h4: aop = c8_pkg::ALU_ADD;
               4'h5: aop = c8_pkg::ALU_SUB;
               4'h6: aop = c8_pkg::ALU_SHR;
               4'h7: aop = c8_pkg::ALU_SUBN;
               4'hE: aop = c8_pkg::ALU_SHL;
               default: aop = c8_pkg::ALU_MOV;
            endcase
            if (b0_ff[7:4] == 4'h7) begin
               aop = c8_pkg::ALU_ADDK;
               ab  = b1_ff;
            end
         end
         default: ;
      endcase
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = valid_ff;
   assign rsp_read_data = rd_ff;
   assign rsp_pc_after = pc_ff;
   assign rsp_illegal_opcode = ill_ff;
   assign rsp_display_updated = disp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         pstart_ff <= 12'd512;
         sbase_ff  <= 12'd0;
         fbase_ff  <= 12'd80;
         pc_ff     <= 12'd512;
         sp_ff     <= 12'd0;
         idx_ff    <= '0;
         dt_ff     <= '0;
         st_ff     <= '0;
         for (int i = 0; i < 16; i++) v_ff[i] <= '0;
         cnt_ff    <= '0;
         valid_ff  <= 1'b0;
      end else begin
         valid_ff <= 1'b0;
         if (csr_write) begin
            case (csr_index)
               c8_pkg::CSR_PROGRAM_START: begin
                  pstart_ff <= csr_data;
                  pc_ff <= csr_data;
               end
               c8_pkg::CSR_STACK_BASE: begin
                  sbase_ff <= csr_data;
                  sp_ff <= csr_data;
               end
               c8_pkg::CSR_FONT_BASE: fbase_ff <= csr_data;
               default: ;
            endcase
         end
         case (state_ff)
            S_CLEAR: begin
               cnt_ff <= cnt_ff + (FR_AW+1)'(1);
               if (cnt_ff == (FR_AW+1)'(FR_BYTES - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: if (start) begin
               rtype_ff <= req_type;
               raddr_ff <= req_address;
               wdata_ff <= req_write_data;
               rnd_ff   <= req_random_byte;
               rd_ff    <= '0;
               ill_ff   <= 1'b0;
               disp_ff  <= 1'b0;
               cnt_ff   <= '0;
               step_ff  <= '0;
               hit_ff   <= 1'b0;
               case (req_type)
                  c8_pkg::REQ_WRITE, c8_pkg::REQ_READ: state_ff <= S_MRD;
                  c8_pkg::REQ_FRAME: state_ff <= S_FRD;
                  default: state_ff <= S_F0;
               endcase
            end
            S_MRD: state_ff <= (rtype_ff == c8_pkg::REQ_WRITE) ? S_DONE : S_MWAIT;
            S_MWAIT: begin
               rd_ff <= ram_q_ff;
               state_ff <= S_DONE;
            end
            S_FRD: state_ff <= S_FWAIT;
            S_FWAIT: begin
               rd_ff <= frame_q_ff;
               state_ff <= S_DONE;
            end
            S_F0: state_ff <= S_F1;
            S_F1: begin
               b0_ff <= ram_q_ff;
               state_ff <= S_F2;
            end
            S_F2: begin
               b1_ff <= ram_q_ff;
               state_ff <= S_DEC;
            end
            S_DEC: begin
               state_ff <= S_DONE;
               pc_ff <= pc2;
               case (b0_ff[7:4])
                  4'h0: begin
                     if (b1_ff == 8'hE0) begin
                        disp_ff <= 1'b1;
                        cnt_ff <= '0;
                        state_ff <= S_CLR;
                     end else if (b1_ff == 8'hEE) begin
                        sp_ff <= sp_ff - 12'd2;
                        pc_ff <= pc_ff;
                        state_ff <= S_RET0;
                     end else begin
                        ill_ff <= 1'b1;
                        pc_ff <= pc_ff;
                     end
                  end
                  4'h1: pc_ff <= nnn;
                  4'h2: begin
                     pc_ff <= pc_ff;
                     state_ff <= S_SCALL;
                  end
                  4'h3: if (vx == b1_ff) pc_ff <= pc4;
                  4'h4: if (vx != b1_ff) pc_ff <= pc4;
                  4'h5: if (vx == vy) pc_ff <= pc4;
                  4'h6: v_ff[x] <= b1_ff;
                  4'h7: v_ff[x] <= ares.result;
                  4'h8: begin
                     if (n == 4'h0 || n == 4'h1 || n == 4'h2 || n == 4'h3) begin
                        v_ff[x] <= ares.result;
                     end else if (n == 4'h4 || n == 4'h5 || n == 4'h6 ||
                                  n == 4'h7 || n == 4'hE) begin
                        v_ff[15] <= {7'd0, ares.flag};
                        v_ff[x] <= ares.result;
                     end else begin
                        ill_ff <= 1'b1;
                        pc_ff <= pc_ff;
                     end
                  end
                  4'h9: if (vx != vy) pc_ff <= pc4;
                  4'hA: idx_ff <= {4'h0, nnn};
                  4'hB: pc_ff <= nnn + {4'h0, v_ff[0]};
                  4'hC: v_ff[x] <= rnd_ff & b1_ff;
                  4'hD: begin
                     disp_ff <= 1'b1;
                     pc_ff <= pc_ff;
                     state_ff <= (n == 4'h0) ? S_DRW : S_DROW;
                  end
                  4'hE: if (b1_ff != 8'h9E && b1_ff != 8'hA1) begin
                     ill_ff <= 1'b1;
                     pc_ff <= pc_ff;
                  end
                  default: begin
                     case (b1_ff)
                        8'h07: v_ff[x] <= dt_ff;
                        8'h0A: ;
                        8'h15: dt_ff <= vx;
                        8'h18: st_ff <= vx;
                        8'h1E: idx_ff <= idx_ff + {8'h00, vx};
                        8'h29: idx_ff <= {4'h0, fbase_ff}
                                         + {6'd0, vx, 2'b00} + {8'h00, vx};
                        8'h33: begin
                           pc_ff <= pc_ff;
                           state_ff <= S_BCD;
                        end
                        8'h55, 8'h65: begin
                           pc_ff <= pc_ff;
                           state_ff <= S_BLK;
                        end
                        default: begin
                           ill_ff <= 1'b1;
                           pc_ff <= pc_ff;
                        end
                     endcase
                  end
               endcase
            end
            S_CLR: begin
               cnt_ff <= cnt_ff + (FR_AW+1)'(1);
               if (cnt_ff == (FR_AW+1)'(FR_BYTES - 1)) state_ff <= S_DONE;
            end
            S_SCALL: begin
               cnt_ff <= cnt_ff + (FR_AW+1)'(1);
               if (cnt_ff[0]) begin
                  sp_ff <= sp_ff + 12'd2;
                  pc_ff <= nnn;
                  state_ff <= S_DONE;
               end
            end
            S_RET0: state_ff <= S_RET1;
            S_RET1: begin
               pc_ff[11:8] <= ram_q_ff[3:0];
               state_ff <= S_RET2;
            end
            S_RET2: begin
               pc_ff[7:0] <= ram_q_ff;
               state_ff <= S_DONE;
            end
            S_BCD: begin
               cnt_ff <= cnt_ff + (FR_AW+1)'(1);
               if (cnt_ff[1:0] == 2'd2) begin
                  pc_ff <= pc2;
                  state_ff <= S_DONE;
               end
            end
            S_BLK: state_ff <= S_BLKW;
            S_BLKW: begin
               if (b1_ff == 8'h65) v_ff[cnt_ff[3:0]] <= ram_q_ff;
               cnt_ff <= cnt_ff + (FR_AW+1)'(1);
               if (cnt_ff[3:0] == x) begin
                  pc_ff <= pc2;
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_BLK;
               end
            end
            S_DROW: state_ff <= S_DROWW;
            S_DROWW: begin
               line_ff <= {ram_q_ff, 8'h00};
               cnt_ff <= '0;
               state_ff <= S_DRD;
            end
            S_DRD: state_ff <= S_DWR;
            S_DWR: begin
               if ((frame_q_ff & dmask) != 8'h00) hit_ff <= 1'b1;
               cnt_ff <= cnt_ff + (FR_AW+1)'(1);
               if (cnt_ff[0]) begin
                  step_ff <= step_ff + 5'd1;
                  state_ff <= (5'(n) == step_ff + 5'd1) ? S_DRW : S_DROW;
               end else begin
                  state_ff <= S_DRD;
               end
            end
            S_DRW: begin
               v_ff[15] <= {7'd0, hit_ff};
               pc_ff <= pc2;
               state_ff <= S_DONE;
            end
            S_DONE: begin
               valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
